// ----- rtl/sfa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segregated-fit allocator package
// Shared constants, status codes and the memory control type.
// ----------------------------------------------------------------------------
package sfa_pkg;
    localparam int CLASS_COUNT     = 5;
    localparam int SLOTS_PER_CLASS = 16;
    localparam int REQUEST_PAD     = 8;
    localparam int ADDRESS_WIDTH   = 32;
    localparam int LEN_W           = 25;
    localparam int OUT_W           = 32;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    localparam logic [0:0] ACT_ALLOC = 1'b0;
    localparam logic [0:0] ACT_FREE  = 1'b1;

    localparam logic [0:0] REG_BASE = 1'b0;
    localparam logic [0:0] REG_SIZE = 1'b1;

    // Memory access request from the sequencer to the extent store.
    typedef struct packed {
        logic        rd_en;
        logic [15:0] rd_addr;
        logic        wr_en;
        logic [15:0] wr_addr;
        logic        wr_valid;
    } t_mem_ctl;
endpackage

// ----- rtl/sfa_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent store
// Start and length memory with flip-flop valid bits and a registered read.
// ----------------------------------------------------------------------------
module sfa_store #(
    parameter int DEPTH = 80,
    parameter int AW    = 32,
    parameter int IW    = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  sfa_pkg::t_mem_ctl     i_ctl,
    input  logic [AW-1:0]         i_wr_start,
    input  logic [sfa_pkg::LEN_W-1:0] i_wr_len,
    output logic [AW-1:0]         o_rd_start,
    output logic [sfa_pkg::LEN_W-1:0] o_rd_len,
    output logic                  o_rd_valid
);
    logic [AW-1:0]             r_start [DEPTH];
    logic [sfa_pkg::LEN_W-1:0] r_len   [DEPTH];
    logic [DEPTH-1:0]          r_valid;
    logic [IW-1:0]             w_wa;
    logic [IW-1:0]             w_ra;

    assign w_wa = i_ctl.wr_addr[IW-1:0];
    assign w_ra = i_ctl.rd_addr[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && i_ctl.wr_valid) begin
            r_start[w_wa] <= i_wr_start;
            r_len[w_wa]   <= i_wr_len;
        end
        if (i_ctl.rd_en) begin
            o_rd_start <= r_start[w_ra];
            o_rd_len   <= r_len[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid    <= '0;
            o_rd_valid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[w_wa] <= i_ctl.wr_valid;
            end
            if (i_ctl.rd_en) begin
                o_rd_valid <= r_valid[w_ra];
            end
        end
    end
endmodule

// ----- rtl/segregated_fit_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segregated-fit allocator
// Address-range allocator with size-class extent tables and a bump pointer.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                     Contents
// s_axis   in   tvalid tready tdata         request word
// m_axis   out  tvalid tready tdata         response word
// cfg      in   i_cfg_we i_cfg_idx i_cfg_data register write
//
// A search reads each slot of its class and then checks it. An allocate that
// finds no fitting slot falls through to the bump region, and an alignment
// gap left by a grant is then filed as a free extent. A free searches its
// class for an empty slot, and a zero-size word goes straight to the answer.
// The next word can be taken in the cycle after the answer is registered.
// A register write clears the valid bits at once. A stall on m_axis holds
// the answer in the output register, and a finished answer waits in its
// state until that register is free.
// ----------------------------------------------------------------------------
module segregated_fit_allocator #(
    parameter int CLASS_COUNT     = sfa_pkg::CLASS_COUNT,
    parameter int SLOTS_PER_CLASS = sfa_pkg::SLOTS_PER_CLASS,
    parameter int REQUEST_PAD     = sfa_pkg::REQUEST_PAD,
    parameter int ADDRESS_WIDTH   = sfa_pkg::ADDRESS_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[0], size[25:1], align_log2[29:26], address[61:30], zero pad
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // block_address[31:0], status[33:32], zero pad
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int LW    = sfa_pkg::LEN_W;
    localparam int AW    = ADDRESS_WIDTH;
    localparam int DEPTH = CLASS_COUNT * SLOTS_PER_CLASS;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(SLOTS_PER_CLASS + 1);
    localparam int CW    = $clog2(CLASS_COUNT);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;
    localparam logic [3:0] S_SCHK  = 4'd2;
    localparam logic [3:0] S_BUMP  = 4'd3;
    localparam logic [3:0] S_FRD   = 4'd4;
    localparam logic [3:0] S_FCHK  = 4'd5;
    localparam logic [3:0] S_OUT   = 4'd6;
    localparam logic [3:0] S_CLS   = 4'd7;

    logic [3:0]    r_state, n_state;
    logic [31:0]   r_base;
    logic [LW-1:0] r_psize;
    logic [AW-1:0] r_bump, n_bump;
    logic          r_act;
    logic [LW-1:0] r_size;
    logic [3:0]    r_lg;
    logic [AW-1:0] r_addr;
    logic [CW-1:0] r_cls, n_cls;
    logic [SW-1:0] r_slot, n_slot;
    logic [AW-1:0] r_fstart, n_fstart;
    logic [LW-1:0] r_flen, n_flen;
    logic [1:0]    r_stat, n_stat;
    logic [AW-1:0] r_grant, n_grant;
    logic          r_ovalid;
    logic [31:0]   r_obaddr;
    logic [1:0]    r_ostat;
    logic          w_fire;
    logic          w_ofree;

    sfa_pkg::t_mem_ctl w_ctl;
    logic [AW-1:0]     w_wstart;
    logic [LW-1:0]     w_wlen;
    logic [AW-1:0]     w_rstart;
    logic [LW-1:0]     w_rlen;
    logic              w_rvalid;

    sfa_store #(.DEPTH(DEPTH), .AW(AW), .IW(IW)) u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_clear(i_cfg_we),
        .i_ctl(w_ctl), .i_wr_start(w_wstart), .i_wr_len(w_wlen),
        .o_rd_start(w_rstart), .o_rd_len(w_rlen), .o_rd_valid(w_rvalid)
    );

    function automatic logic [CW-1:0] f_class(input logic [LW:0] len);
        logic [CW-1:0] c;
        c = CW'(CLASS_COUNT - 1);
        for (int i = CLASS_COUNT - 2; i >= 0; i--) begin
            if ({8'd0, len} <= (34'd64 << i)) c = CW'(i);
        end
        return c;
    endfunction

    logic [AW:0]   w_amask;
    logic [AW-1:0] w_amk;
    logic [IW-1:0] w_idx;
    // Slot check datapath.
    logic [AW-1:0] w_al;
    logic [AW:0]   w_gap;
    logic          w_fit;
    logic [LW:0]   w_rem;
    // Bump datapath.
    logic [AW:0]   w_top;
    logic [AW-1:0] w_bal;
    logic          w_bok;

    assign w_amask = ({{AW{1'b0}}, 1'b1} << r_lg) - 1'b1;
    assign w_amk   = w_amask[AW-1:0];
    assign w_idx   = IW'(r_cls * SLOTS_PER_CLASS + r_slot);

    always_comb begin
        logic [AW:0] s1;
        s1    = {1'b0, w_rstart} + {1'b0, w_amk};
        w_al  = s1[AW-1:0] & ~w_amk;
        w_gap = {1'b0, w_al} - {1'b0, w_rstart};
        w_fit = w_rvalid && (w_rlen >= r_size) && !s1[AW]
                && (w_gap <= (AW+1)'(w_rlen))
                && ((AW+1)'(w_rlen) - w_gap >= (AW+1)'(r_size));
        w_rem = (LW+1)'((AW+1)'(w_rlen) - w_gap - (AW+1)'(r_size));
    end

    always_comb begin
        logic [AW:0] b1;
        w_top = {1'b0, AW'(r_base)} + (AW+1)'(r_psize);
        if (w_top[AW]) w_top = {1'b0, {AW{1'b1}}};
        b1    = {1'b0, r_bump} + {1'b0, w_amk};
        w_bal = b1[AW-1:0] & ~w_amk;
        w_bok = !b1[AW] && ({1'b0, w_bal} <= w_top)
                && (w_top - {1'b0, w_bal} >= (AW+1)'(r_size));
    end

    assign w_fire  = s_axis_tvalid && s_axis_tready;
    assign w_ofree = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !i_cfg_we;

    always_comb begin
        n_state  = r_state;
        n_bump   = r_bump;
        n_cls    = r_cls;
        n_slot   = r_slot;
        n_fstart = r_fstart;
        n_flen   = r_flen;
        n_stat   = r_stat;
        n_grant  = r_grant;
        w_ctl    = '0;
        w_wstart = r_fstart;
        w_wlen   = r_flen;
        unique case (r_state)
            S_IDLE: begin
                if (w_fire) n_state = S_CLS;
            end
            S_CLS: begin
                n_slot  = '0;
                n_grant = '0;
                n_stat  = sfa_pkg::ST_OK;
                if (r_size == '0) begin
                    n_stat  = sfa_pkg::ST_ZERO;
                    n_state = S_OUT;
                end else if (r_act == sfa_pkg::ACT_ALLOC) begin
                    n_cls   = f_class((LW+1)'(r_size) + (LW+1)'(REQUEST_PAD));
                    n_state = S_SRD;
                end else begin
                    n_fstart = r_addr;
                    n_flen   = r_size;
                    n_cls    = f_class((LW+1)'(r_size));
                    n_state  = S_FRD;
                end
            end
            S_SRD: begin
                if (r_slot == SW'(SLOTS_PER_CLASS)) begin
                    n_state = S_BUMP;
                end else begin
                    w_ctl.rd_en   = 1'b1;
                    w_ctl.rd_addr = 16'(w_idx);
                    n_state       = S_SCHK;
                end
            end
            S_SCHK: begin
                if (w_fit) begin
                    w_ctl.wr_en    = 1'b1;
                    w_ctl.wr_addr  = 16'(w_idx);
                    w_ctl.wr_valid = (w_rem != '0);
                    w_wstart       = w_al + AW'(r_size);
                    w_wlen         = LW'(w_rem);
                    n_grant        = w_al;
                    if (w_gap != '0) begin
                        n_fstart = w_rstart;
                        n_flen   = LW'(w_gap);
                        n_cls    = f_class((LW+1)'(w_gap));
                        n_slot   = '0;
                        n_state  = S_FRD;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = S_SRD;
                end
            end
            S_BUMP: begin
                if (!w_bok) begin
                    n_stat  = sfa_pkg::ST_OOM;
                    n_state = S_OUT;
                end else begin
                    n_bump  = w_bal + AW'(r_size);
                    n_grant = w_bal;
                    if (w_bal != r_bump) begin
                        n_fstart = r_bump;
                        n_flen   = LW'(w_bal - r_bump);
                        n_cls    = f_class((LW+1)'(w_bal - r_bump));
                        n_slot   = '0;
                        n_state  = S_FRD;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_FRD: begin
                if (r_slot == SW'(SLOTS_PER_CLASS)) begin
                    n_stat  = sfa_pkg::ST_FULL;
                    n_state = S_OUT;
                end else begin
                    w_ctl.rd_en   = 1'b1;
                    w_ctl.rd_addr = 16'(w_idx);
                    n_state       = S_FCHK;
                end
            end
            S_FCHK: begin
                if (!w_rvalid) begin
                    w_ctl.wr_en    = 1'b1;
                    w_ctl.wr_addr  = 16'(w_idx);
                    w_ctl.wr_valid = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    n_slot  = r_slot + 1'b1;
                    n_state = S_FRD;
                end
            end
            S_OUT: begin
                // The answer moves out only when the output register is free.
                if (w_ofree) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= '0;
            r_psize  <= LW'(65536);
            r_bump   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (i_cfg_we) begin
                r_state <= S_IDLE;
                if (i_cfg_idx == sfa_pkg::REG_BASE) begin
                    r_base <= i_cfg_data;
                    r_bump <= AW'(i_cfg_data);
                end else begin
                    r_psize <= i_cfg_data[LW-1:0];
                    r_bump  <= AW'(r_base);
                end
            end else begin
                r_state <= n_state;
                r_bump  <= n_bump;
                if (r_state == S_OUT && w_ofree) r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cls    <= n_cls;
        r_slot   <= n_slot;
        r_fstart <= n_fstart;
        r_flen   <= n_flen;
        r_stat   <= n_stat;
        r_grant  <= n_grant;
        if (w_fire) begin
            r_act  <= s_axis_tdata[0];
            r_size <= s_axis_tdata[25:1];
            r_lg   <= s_axis_tdata[29:26];
            r_addr <= AW'(s_axis_tdata[61:30]);
        end
        if (r_state == S_OUT && w_ofree) begin
            r_obaddr <= 32'(r_grant);
            r_ostat  <= r_stat;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_ostat, r_obaddr};
endmodule

// ----- sim/tb_segregated_fit_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segregated-fit allocator testbench
// Drives allocate and free words with random gaps and output stalls. A
// predictor of the extent tables and the bump pointer supplies the expected
// grant for each accepted word. Every response is compared in order. The
// pool registers are rewritten between phases, including the extreme values.
// ----------------------------------------------------------------------------
module tb_segregated_fit_allocator;
    localparam int                SLOT_TOTAL = sfa_pkg::CLASS_COUNT * sfa_pkg::SLOTS_PER_CLASS;
    localparam longint unsigned   ADDR_MAX   = 64'hFFFF_FFFF;
    localparam int                SETTLE     = 2 * (2 * sfa_pkg::SLOTS_PER_CLASS + 6) + 20;
    localparam int                CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  status;
    } t_grant;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    segregated_fit_allocator dut (.*);

    // Predicted allocator state.
    longint unsigned pool_base_q;
    longint unsigned pool_size_q;
    longint unsigned bump_q;
    longint unsigned ext_start [SLOT_TOTAL];
    longint unsigned ext_len   [SLOT_TOTAL];
    bit              ext_vld   [SLOT_TOTAL];

    t_grant grant_q[$];
    int     fail_cnt;
    int     cycle_cnt;
    int     hold_cnt;
    int     stall_cnt;
    bit     calm;

    // Blocks currently handed out, used to build well-formed frees.
    logic [31:0] live_addr[$];
    logic [24:0] live_size[$];

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int size_class(input longint unsigned len);
        for (int c = 0; c < sfa_pkg::CLASS_COUNT - 1; c++) begin
            if (len <= (64'd64 << c)) return c;
        end
        return sfa_pkg::CLASS_COUNT - 1;
    endfunction

    function automatic bit file_extent(input longint unsigned st, input longint unsigned len);
        int b;
        b = size_class(len) * sfa_pkg::SLOTS_PER_CLASS;
        for (int s = 0; s < sfa_pkg::SLOTS_PER_CLASS; s++) begin
            if (!ext_vld[b + s]) begin
                ext_vld[b + s]   = 1'b1;
                ext_start[b + s] = st & ADDR_MAX;
                ext_len[b + s]   = len & 64'h1FF_FFFF;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void clear_tables();
        for (int k = 0; k < SLOT_TOTAL; k++) ext_vld[k] = 1'b0;
        bump_q = pool_base_q;
    endfunction

    function automatic t_grant predict_grant(input logic act, input logic [24:0] sz,
                                             input logic [3:0] lg, input logic [31:0] a);
        t_grant          g;
        longint unsigned amask, st, len, al, gap, top;
        int              b, k;
        bit              done;
        g = '0;
        done = 1'b0;
        if (sz == 0) begin
            g.status = sfa_pkg::ST_ZERO;
        end else if (act == sfa_pkg::ACT_FREE) begin
            g.status = file_extent(a, sz) ? sfa_pkg::ST_OK : sfa_pkg::ST_FULL;
        end else begin
            amask = (64'd1 << lg) - 1;
            b = size_class(sz + sfa_pkg::REQUEST_PAD) * sfa_pkg::SLOTS_PER_CLASS;
            g.status = sfa_pkg::ST_OOM;
            for (int s = 0; s < sfa_pkg::SLOTS_PER_CLASS; s++) begin
                k = b + s;
                if (!done && ext_vld[k] && ext_len[k] >= sz && ext_start[k] <= ADDR_MAX - amask)
                begin
                    st = ext_start[k];
                    len = ext_len[k];
                    al = (st + amask) & ~amask;
                    gap = al - st;
                    if (gap <= len && len - gap >= sz) begin
                        done = 1'b1;
                        if (len - gap - sz > 0) begin
                            ext_start[k] = (al + sz) & ADDR_MAX;
                            ext_len[k]   = len - gap - sz;
                        end else begin
                            ext_vld[k] = 1'b0;
                        end
                        g.addr = al[31:0];
                        g.status = (gap > 0 && !file_extent(st, gap)) ?
                                   sfa_pkg::ST_FULL : sfa_pkg::ST_OK;
                    end
                end
            end
            if (!done) begin
                // Bump region; its end saturates at the top of the address space.
                top = pool_base_q + pool_size_q;
                if (top > ADDR_MAX) top = ADDR_MAX;
                if (bump_q <= ADDR_MAX - amask) begin
                    al = (bump_q + amask) & ~amask;
                    if (al <= top && top - al >= sz) begin
                        gap = al - bump_q;
                        st = bump_q;
                        bump_q = (al + sz) & ADDR_MAX;
                        g.addr = al[31:0];
                        g.status = (gap > 0 && !file_extent(st, gap)) ?
                                   sfa_pkg::ST_FULL : sfa_pkg::ST_OK;
                    end
                end
            end
        end
        return g;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // Output side: random stalls, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            m_axis_tready = 1'b0;
            hold_cnt = hold_cnt - 1;
        end else if (stall_cnt > 0) begin
            m_axis_tready = 1'b0;
            stall_cnt = stall_cnt - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            m_axis_tready = 1'b0;
            stall_cnt = gap_len();
        end else begin
            m_axis_tready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_grant got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.addr = m_axis_tdata[31:0];
            got.status = m_axis_tdata[33:32];
            if (grant_q.size() == 0) begin
                $display("%0t: unexpected word, actual addr %h status %0d",
                         $time, got.addr, got.status);
                fail_cnt++;
            end else begin
                want = grant_q.pop_front();
                if (got.addr !== want.addr) begin
                    $display("%0t: block_address expected %h actual %h",
                             $time, want.addr, got.addr);
                    fail_cnt++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    fail_cnt++;
                end
            end
        end
    end

    task automatic send_req(input logic act, input logic [24:0] sz,
                            input logic [3:0] lg, input logic [31:0] a);
        int     idle;
        t_grant g;
        idle = gap_len();
        if (idle > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (idle - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {2'b00, a, lg, sz, act};
        do @(posedge i_clk); while (!s_axis_tready);
        g = predict_grant(act, sz, lg, a);
        grant_q = {grant_q, g};
        if (act == sfa_pkg::ACT_ALLOC && g.status != sfa_pkg::ST_OOM
            && g.status != sfa_pkg::ST_ZERO) begin
            live_addr = {live_addr, g.addr};
            live_size = {live_size, sz};
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] val);
        drain();
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == sfa_pkg::REG_BASE) pool_base_q = val;
        else pool_size_q = val[24:0];
        clear_tables();
        live_addr.delete();
        live_size.delete();
    endtask

    task automatic test_directed();
        cfg_write(sfa_pkg::REG_BASE, 32'h0000_0000);
        cfg_write(sfa_pkg::REG_SIZE, 32'd65536);
        send_req(sfa_pkg::ACT_ALLOC, 25'd0, 4'd0, 32'h0);
        send_req(sfa_pkg::ACT_FREE, 25'd0, 4'd0, 32'hFFFF_FFFF);
        // Fill the smallest class by frees; the last one finds it full.
        for (int i = 0; i < 17; i++) begin
            send_req(sfa_pkg::ACT_FREE, 25'd8, 4'd0, 32'h8000 + 16 * i);
        end
        // Bump allocation leaving an alignment gap that has nowhere to go.
        send_req(sfa_pkg::ACT_ALLOC, 25'd200, 4'd0, 32'h0);
        send_req(sfa_pkg::ACT_ALLOC, 25'd100, 4'd6, 32'h0);
        send_req(sfa_pkg::ACT_FREE, 25'd40, 4'd0, 32'h0);
        send_req(sfa_pkg::ACT_FREE, 25'd16777216, 4'd0, 32'hFFFF_FFFF);
        send_req(sfa_pkg::ACT_FREE, 25'd3000, 4'd0, 32'h0001_0001);
        // Extent whose aligned start falls past its end is skipped.
        send_req(sfa_pkg::ACT_ALLOC, 25'd2500, 4'd12, 32'h0);
        send_req(sfa_pkg::ACT_ALLOC, 25'd1, 4'd15, 32'h0);
        send_req(sfa_pkg::ACT_ALLOC, 25'd16777216, 4'd0, 32'h0);
        send_req(sfa_pkg::ACT_ALLOC, 25'd1, 4'd0, 32'h0);
    endtask

    task automatic test_saturated_pool();
        cfg_write(sfa_pkg::REG_BASE, 32'hFFFF_F000);
        cfg_write(sfa_pkg::REG_SIZE, 32'd16777216);
        send_req(sfa_pkg::ACT_ALLOC, 25'd4000, 4'd0, 32'h0);
        send_req(sfa_pkg::ACT_ALLOC, 25'd95, 4'd0, 32'h0);
        send_req(sfa_pkg::ACT_ALLOC, 25'd1, 4'd13, 32'h0);
        send_req(sfa_pkg::ACT_FREE, 25'd64, 4'd0, 32'hFFFF_FFC0);
        send_req(sfa_pkg::ACT_ALLOC, 25'd8, 4'd14, 32'h0);
        send_req(sfa_pkg::ACT_ALLOC, 25'd8, 4'd5, 32'h0);
    endtask

    task automatic random_mix(input int count);
        int          r, j;
        logic [24:0] sz;
        logic [3:0]  lg;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                j = $urandom_range(0, 99);
                if (j < 80) sz = 25'($urandom_range(1, 600));
                else if (j < 97) sz = 25'($urandom_range(1, 8192));
                else sz = 25'($urandom_range(0, 16777216));
                j = $urandom_range(0, 9);
                lg = (j < 7) ? 4'($urandom_range(0, 6)) : 4'($urandom_range(0, 15));
                send_req(sfa_pkg::ACT_ALLOC, sz, lg, $urandom());
            end else if (r < 92 && live_addr.size() != 0) begin
                j = $urandom_range(0, live_addr.size() - 1);
                send_req(sfa_pkg::ACT_FREE, live_size[j], 4'($urandom()), live_addr[j]);
                live_addr.delete(j);
                live_size.delete(j);
            end else begin
                sz = ($urandom_range(0, 9) == 0) ? 25'd0 : 25'($urandom_range(1, 16777216));
                send_req(1'($urandom()), sz, 4'($urandom()), $urandom());
            end
        end
    endtask

    task automatic test_random();
        cfg_write(sfa_pkg::REG_SIZE, 32'd65536);
        cfg_write(sfa_pkg::REG_BASE, 32'h1000_0000);
        random_mix(450);
        cfg_write(sfa_pkg::REG_SIZE, 32'd4096);
        random_mix(450);
        cfg_write(sfa_pkg::REG_SIZE, 32'd0);
        random_mix(60);
        cfg_write(sfa_pkg::REG_BASE, $urandom());
        cfg_write(sfa_pkg::REG_SIZE, 32'd16777216);
        random_mix(450);
        calm = 1'b1;
        random_mix(150);
        calm = 1'b0;
        cfg_write(sfa_pkg::REG_BASE, 32'hFFFF_FFFF);
        random_mix(100);
    endtask

    task automatic test_backpressure();
        cfg_write(sfa_pkg::REG_BASE, 32'h0);
        cfg_write(sfa_pkg::REG_SIZE, 32'd65536);
        @(posedge i_clk);
        hold_cnt = 400;
        random_mix(20);
        drain();
        random_mix(20);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = sfa_pkg::REG_BASE;
        i_cfg_data = '0;
        fail_cnt = 0;
        cycle_cnt = 0;
        hold_cnt = 0;
        stall_cnt = 0;
        calm = 1'b0;
        pool_base_q = 0;
        pool_size_q = 65536;
        clear_tables();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_saturated_pool();
        test_backpressure();
        test_random();
        drain();
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/sfa_pkg.sv
rtl/sfa_store.sv
rtl/segregated_fit_allocator.sv
sim/tb_segregated_fit_allocator.sv
